// ===== hw/rtl/mrpt_pkg.sv =====
// mrpt_pkg: shared constants, tables and controller/datapath interface types
// for the 64-bit primality tester; no dependencies
package mrpt_pkg;

  localparam int TRIAL_PRIMES = 168;
  localparam int NUM_BASES    = 6;

  localparam logic [7:0] LAST_PRIME = 8'(TRIAL_PRIMES - 1);
  localparam logic [2:0] LAST_BASE  = 3'(NUM_BASES - 1);

  // outcome codes
  localparam logic [2:0] OC_BELOW_TWO    = 3'd0;
  localparam logic [2:0] OC_SMALL_PRIME  = 3'd1;
  localparam logic [2:0] OC_SMALL_FACTOR = 3'd2;
  localparam logic [2:0] OC_WITNESS      = 3'd3;
  localparam logic [2:0] OC_PASSED       = 3'd4;

  // montgomery operand selection
  localparam logic [1:0] MS_A_R2    = 2'd0;
  localparam logic [1:0] MS_ACC_X   = 2'd1;
  localparam logic [1:0] MS_X_X     = 2'd2;
  localparam logic [1:0] MS_ACC_ACC = 2'd3;

  localparam logic [9:0] PRIME_TAB [168] = '{
    10'd2, 10'd3, 10'd5, 10'd7, 10'd11, 10'd13, 10'd17, 10'd19, 10'd23, 10'd29,
    10'd31, 10'd37, 10'd41, 10'd43, 10'd47, 10'd53, 10'd59, 10'd61, 10'd67, 10'd71,
    10'd73, 10'd79, 10'd83, 10'd89, 10'd97, 10'd101, 10'd103, 10'd107, 10'd109, 10'd113,
    10'd127, 10'd131, 10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167,
    10'd173, 10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223,
    10'd227, 10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263, 10'd269,
    10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311, 10'd313, 10'd317,
    10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359, 10'd367, 10'd373, 10'd379,
    10'd383, 10'd389, 10'd397, 10'd401, 10'd409, 10'd419, 10'd421, 10'd431, 10'd433,
    10'd439, 10'd443, 10'd449, 10'd457, 10'd461, 10'd463, 10'd467, 10'd479, 10'd487,
    10'd491, 10'd499, 10'd503, 10'd509, 10'd521, 10'd523, 10'd541, 10'd547, 10'd557,
    10'd563, 10'd569, 10'd571, 10'd577, 10'd587, 10'd593, 10'd599, 10'd601, 10'd607,
    10'd613, 10'd617, 10'd619, 10'd631, 10'd641, 10'd643, 10'd647, 10'd653, 10'd659,
    10'd661, 10'd673, 10'd677, 10'd683, 10'd691, 10'd701, 10'd709, 10'd719, 10'd727,
    10'd733, 10'd739, 10'd743, 10'd751, 10'd757, 10'd761, 10'd769, 10'd773, 10'd787,
    10'd797, 10'd809, 10'd811, 10'd821, 10'd823, 10'd827, 10'd829, 10'd839, 10'd853,
    10'd857, 10'd859, 10'd863, 10'd877, 10'd881, 10'd883, 10'd887, 10'd907, 10'd911,
    10'd919, 10'd929, 10'd937, 10'd941, 10'd947, 10'd953, 10'd967, 10'd971, 10'd977,
    10'd983, 10'd991, 10'd997
  };

  localparam logic [3:0] BASE_TAB [6] = '{4'd2, 4'd3, 4'd5, 4'd7, 4'd11, 4'd13};

  typedef struct packed {
    logic       load_n;
    logic       td_clr;
    logic       td_step;
    logic [7:0] td_pidx;
    logic [2:0] td_chunk;
    logic       su_init;
    logic       su_step;
    logic [6:0] su_cnt;
    logic       base_load;
    logic [2:0] base_idx;
    logic       base_sub;
    logic       mm_start;
    logic [1:0] mm_sel;
    logic       x_wr;
    logic       acc_wr;
    logic       acc_init;
    logic       e_shift;
    logic       sq_init;
    logic       rcnt_inc;
  } mrpt_cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic td_eq;
    logic td_zero;
    logic a_ge_n;
    logic a_zero;
    logic mm_done;
    logic e_zero;
    logic e_lsb;
    logic e_one;
    logic acc_is_r1;
    logic acc_is_m1;
    logic res_is_m1;
    logic sq_left;
  } mrpt_sts_t;

endpackage

// ===== hw/rtl/mrpt_mont.sv =====
// mrpt_mont: 64-bit montgomery multiplier, R = 2^64, built on one 32x32 multiplier
// stand-alone, no package use
module mrpt_mont (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  input  logic [63:0] modulus,
  input  logic [63:0] ninv,
  output logic        done,
  output logic [63:0] res
);

  localparam logic [1:0] PH_P = 2'd0;  // t = a * b
  localparam logic [1:0] PH_M = 2'd1;  // m = t_lo * ninv mod 2^64
  localparam logic [1:0] PH_Q = 2'd2;  // t += m * n
  localparam logic [1:0] PH_R = 2'd3;  // final subtract

  logic         busy_r, done_r, pv_r;
  logic [1:0]   phase_r;
  logic [2:0]   step_r;
  logic [63:0]  ma_r, mb_r, m_r, p_r, res_r;
  logic [128:0] t_r;
  logic [1:0]   sh_r;

  logic [63:0]  xs, ys, prod, m_add;
  logic [31:0]  xh, yh;
  logic [128:0] t_add;
  logic [64:0]  h, red;
  logic         issue;

  always_comb begin
    unique case (phase_r)
      PH_P:    begin xs = ma_r;        ys = mb_r;    end
      PH_M:    begin xs = t_r[63:0];   ys = ninv;    end
      default: begin xs = m_r;         ys = modulus; end
    endcase
    xh    = step_r[1] ? xs[63:32] : xs[31:0];
    yh    = step_r[0] ? ys[63:32] : ys[31:0];
    prod  = {32'd0, xh} * {32'd0, yh};
    t_add = {65'd0, p_r} << {sh_r, 5'd0};
    m_add = p_r << {sh_r, 5'd0};
    h     = t_r[128:64];
    red   = (h >= {1'b0, modulus}) ? h - {1'b0, modulus} : h;
    issue = busy_r && (phase_r != PH_R) && (step_r != 3'd4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      pv_r    <= 1'b0;
      phase_r <= PH_P;
      step_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      pv_r   <= issue;
      if (start && !busy_r) begin
        busy_r  <= 1'b1;
        phase_r <= PH_P;
        step_r  <= 3'd0;
      end else if (busy_r) begin
        if (phase_r == PH_R) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else if (step_r == 3'd4) begin
          step_r  <= 3'd0;
          phase_r <= phase_r + 2'd1;
        end else begin
          step_r <= step_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      ma_r <= op_a;
      mb_r <= op_b;
      t_r  <= '0;
      m_r  <= '0;
    end else begin
      if (issue) begin
        p_r  <= prod;
        sh_r <= {1'b0, step_r[1]} + {1'b0, step_r[0]};
      end
      if (pv_r) begin
        if (phase_r == PH_M) m_r <= m_r + m_add;
        else t_r <= t_r + t_add;
      end
      if (busy_r && phase_r == PH_R) res_r <= red[63:0];
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== hw/rtl/mrpt_dp.sv =====
// mrpt_dp: datapath of the primality tester: trial remainder, montgomery setup,
// exponent and squaring registers; uses mrpt_pkg and mrpt_mont
module mrpt_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [63:0]         in_candidate,
  input  mrpt_pkg::mrpt_cmd_t cmd,
  output mrpt_pkg::mrpt_sts_t sts
);
  import mrpt_pkg::*;

  logic [63:0] n_r, inv_r, u_r, dbl_r, r1_r, d_r, e_r, a_r, x_r, acc_r, m1_r;
  logic [9:0]  rem_r;
  logic [5:0]  s_r, rcnt_r;

  logic [9:0]  prime;
  logic [10:0] rt;
  logic [9:0]  rem_nxt;
  logic [7:0]  chunk;
  logic [64:0] dv;
  logic [63:0] dbl_nxt;
  logic [63:0] mm_a, mm_b, mm_res;
  logic        mm_done;

  // eight bits of the candidate fold into the remainder per beat, msb chunk first
  always_comb begin
    prime = PRIME_TAB[cmd.td_pidx];
    chunk = n_r[{~cmd.td_chunk, 3'b000} +: 8];
    rt    = {1'b0, rem_r};
    for (int k = 7; k >= 0; k--) begin
      rt = {rt[9:0], chunk[k]};
      if (rt >= {1'b0, prime}) rt = rt - {1'b0, prime};
    end
    rem_nxt = rt[9:0];
  end

  // modular doubling
  always_comb begin
    dv = {dbl_r, 1'b0};
    if (dv >= {1'b0, n_r}) dv = dv - {1'b0, n_r};
    dbl_nxt = dv[63:0];
  end

  always_comb begin
    unique case (cmd.mm_sel)
      MS_A_R2:  begin mm_a = a_r;   mm_b = dbl_r; end
      MS_ACC_X: begin mm_a = acc_r; mm_b = x_r;   end
      MS_X_X:   begin mm_a = x_r;   mm_b = x_r;   end
      default:  begin mm_a = acc_r; mm_b = acc_r; end
    endcase
  end

  mrpt_mont u_mont (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mm_start),
    .op_a    (mm_a),
    .op_b    (mm_b),
    .modulus (n_r),
    .ninv    (inv_r),
    .done    (mm_done),
    .res     (mm_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_n) n_r <= in_candidate;
    if (cmd.td_clr) rem_r <= '0;
    else if (cmd.td_step) rem_r <= (cmd.td_chunk == 3'd7) ? 10'd0 : rem_nxt;

    if (cmd.su_init) begin
      inv_r <= '0;
      u_r   <= 64'd1;
      dbl_r <= 64'd1;
      d_r   <= n_r - 64'd1;
      s_r   <= '0;
    end else if (cmd.su_step) begin
      if (!cmd.su_cnt[6] && u_r[cmd.su_cnt[5:0]]) begin
        inv_r[cmd.su_cnt[5:0]] <= 1'b1;
        u_r <= u_r + (n_r << cmd.su_cnt[5:0]);
      end
      dbl_r <= dbl_nxt;
      if (cmd.su_cnt == 7'd63) r1_r <= dbl_nxt;
      if (!d_r[0]) begin
        d_r <= d_r >> 1;
        s_r <= s_r + 6'd1;
      end
    end

    if (cmd.base_load) begin
      a_r  <= {60'd0, BASE_TAB[cmd.base_idx]};
      m1_r <= n_r - r1_r;
    end else if (cmd.base_sub) begin
      a_r <= a_r - n_r;
    end

    if (cmd.x_wr) x_r <= mm_res;
    if (cmd.acc_init) begin
      acc_r <= r1_r;
      e_r   <= d_r;
    end else begin
      if (cmd.acc_wr) acc_r <= mm_res;
      if (cmd.e_shift) e_r <= e_r >> 1;
    end

    if (cmd.sq_init) rcnt_r <= 6'd1;
    else if (cmd.rcnt_inc) rcnt_r <= rcnt_r + 6'd1;
  end

  always_comb begin
    sts.n_lt2     = (n_r < 64'd2);
    sts.td_eq     = (n_r == {54'd0, prime});
    sts.td_zero   = (rem_nxt == 10'd0);
    sts.a_ge_n    = (a_r >= n_r);
    sts.a_zero    = (a_r == 64'd0);
    sts.mm_done   = mm_done;
    sts.e_zero    = (e_r == 64'd0);
    sts.e_lsb     = e_r[0];
    sts.e_one     = (e_r == 64'd1);
    sts.acc_is_r1 = (acc_r == r1_r);
    sts.acc_is_m1 = (acc_r == m1_r);
    sts.res_is_m1 = (mm_res == m1_r);
    sts.sq_left   = (rcnt_r < s_r);
  end

endmodule

// ===== hw/rtl/mrpt_ctrl.sv =====
// mrpt_ctrl: sequencing state machine and result register of the primality tester
// uses mrpt_pkg
module mrpt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_is_prime,
  output logic [2:0]          out_outcome,
  input  mrpt_pkg::mrpt_sts_t sts,
  output mrpt_pkg::mrpt_cmd_t cmd
);
  import mrpt_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_TD_INIT   = 4'd1;
  localparam logic [3:0] S_TD        = 4'd2;
  localparam logic [3:0] S_SU_INIT   = 4'd3;
  localparam logic [3:0] S_SU        = 4'd4;
  localparam logic [3:0] S_BASE_INIT = 4'd5;
  localparam logic [3:0] S_BASE_MOD  = 4'd6;
  localparam logic [3:0] S_MM_XA     = 4'd7;
  localparam logic [3:0] S_EXP       = 4'd8;
  localparam logic [3:0] S_MM_ACC    = 4'd9;
  localparam logic [3:0] S_MM_XX     = 4'd10;
  localparam logic [3:0] S_CHECK     = 4'd11;
  localparam logic [3:0] S_SQ        = 4'd12;
  localparam logic [3:0] S_MM_SQ     = 4'd13;
  localparam logic [3:0] S_DONE      = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic [7:0] pidx_r, pidx_nxt;
  logic [2:0] chunk_r, chunk_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [2:0] bidx_r, bidx_nxt;
  logic [2:0] code_r, code_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_is_prime_r;
  logic [2:0] out_outcome_r;
  logic       out_load;

  always_comb begin
    state_nxt    = state_r;
    pidx_nxt     = pidx_r;
    chunk_nxt    = chunk_r;
    cnt_nxt      = cnt_r;
    bidx_nxt     = bidx_r;
    code_nxt     = code_r;
    out_load     = 1'b0;
    cmd          = '0;
    cmd.td_pidx  = pidx_r;
    cmd.td_chunk = chunk_r;
    cmd.su_cnt   = cnt_r;
    cmd.base_idx = bidx_r;

    unique case (state_r)
      S_IDLE: begin
        cmd.load_n = in_valid;
        if (in_valid) state_nxt = S_TD_INIT;
      end
      S_TD_INIT: begin
        if (sts.n_lt2) begin
          code_nxt  = OC_BELOW_TWO;
          state_nxt = S_DONE;
        end else begin
          cmd.td_clr = 1'b1;
          pidx_nxt   = '0;
          chunk_nxt  = '0;
          state_nxt  = S_TD;
        end
      end
      S_TD: begin
        cmd.td_step = 1'b1;
        chunk_nxt   = chunk_r + 3'd1;
        if (chunk_r == 3'd7) begin
          priority if (sts.td_eq) begin
            code_nxt  = OC_SMALL_PRIME;
            state_nxt = S_DONE;
          end else if (sts.td_zero) begin
            code_nxt  = OC_SMALL_FACTOR;
            state_nxt = S_DONE;
          end else if (pidx_r == LAST_PRIME) begin
            state_nxt = S_SU_INIT;
          end else begin
            pidx_nxt = pidx_r + 8'd1;
          end
        end
      end
      S_SU_INIT: begin
        cmd.su_init = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_SU;
      end
      S_SU: begin
        cmd.su_step = 1'b1;
        cnt_nxt     = cnt_r + 7'd1;
        if (cnt_r == 7'd127) begin
          bidx_nxt  = '0;
          state_nxt = S_BASE_INIT;
        end
      end
      S_BASE_INIT: begin
        cmd.base_load = 1'b1;
        state_nxt     = S_BASE_MOD;
      end
      S_BASE_MOD: begin
        priority if (sts.a_ge_n) begin
          cmd.base_sub = 1'b1;
        end else if (sts.a_zero) begin
          if (bidx_r == LAST_BASE) begin
            code_nxt  = OC_PASSED;
            state_nxt = S_DONE;
          end else begin
            bidx_nxt  = bidx_r + 3'd1;
            state_nxt = S_BASE_INIT;
          end
        end else begin
          cmd.mm_start = 1'b1;
          cmd.mm_sel   = MS_A_R2;
          state_nxt    = S_MM_XA;
        end
      end
      S_MM_XA: begin
        if (sts.mm_done) begin
          cmd.x_wr     = 1'b1;
          cmd.acc_init = 1'b1;
          state_nxt    = S_EXP;
        end
      end
      S_EXP: begin
        priority if (sts.e_zero) begin
          state_nxt = S_CHECK;
        end else if (sts.e_lsb) begin
          cmd.mm_start = 1'b1;
          cmd.mm_sel   = MS_ACC_X;
          state_nxt    = S_MM_ACC;
        end else begin
          cmd.mm_start = 1'b1;
          cmd.mm_sel   = MS_X_X;
          state_nxt    = S_MM_XX;
        end
      end
      S_MM_ACC: begin
        cmd.mm_sel = MS_ACC_X;
        if (sts.mm_done) begin
          cmd.acc_wr = 1'b1;
          if (sts.e_one) begin
            // last exponent bit: the final square of x is never used
            cmd.e_shift = 1'b1;
            state_nxt   = S_EXP;
          end else begin
            cmd.mm_start = 1'b1;
            cmd.mm_sel   = MS_X_X;
            state_nxt    = S_MM_XX;
          end
        end
      end
      S_MM_XX: begin
        cmd.mm_sel = MS_X_X;
        if (sts.mm_done) begin
          cmd.x_wr    = 1'b1;
          cmd.e_shift = 1'b1;
          state_nxt   = S_EXP;
        end
      end
      S_CHECK: begin
        if (sts.acc_is_r1 || sts.acc_is_m1) begin
          if (bidx_r == LAST_BASE) begin
            code_nxt  = OC_PASSED;
            state_nxt = S_DONE;
          end else begin
            bidx_nxt  = bidx_r + 3'd1;
            state_nxt = S_BASE_INIT;
          end
        end else begin
          cmd.sq_init = 1'b1;
          state_nxt   = S_SQ;
        end
      end
      S_SQ: begin
        if (sts.sq_left) begin
          cmd.mm_start = 1'b1;
          cmd.mm_sel   = MS_ACC_ACC;
          state_nxt    = S_MM_SQ;
        end else begin
          code_nxt  = OC_WITNESS;
          state_nxt = S_DONE;
        end
      end
      S_MM_SQ: begin
        cmd.mm_sel = MS_ACC_ACC;
        if (sts.mm_done) begin
          cmd.acc_wr   = 1'b1;
          cmd.rcnt_inc = 1'b1;
          if (sts.res_is_m1) begin
            if (bidx_r == LAST_BASE) begin
              code_nxt  = OC_PASSED;
              state_nxt = S_DONE;
            end else begin
              bidx_nxt  = bidx_r + 3'd1;
              state_nxt = S_BASE_INIT;
            end
          end else begin
            state_nxt = S_SQ;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_load | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r  <= pidx_nxt;
    chunk_r <= chunk_nxt;
    cnt_r   <= cnt_nxt;
    bidx_r  <= bidx_nxt;
    code_r  <= code_nxt;
    if (out_load) begin
      out_outcome_r  <= code_r;
      out_is_prime_r <= (code_r == OC_SMALL_PRIME) || (code_r == OC_PASSED);
    end
  end

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;
  assign out_outcome  = out_outcome_r;

endmodule

// ===== hw/rtl/miller_rabin_prime_test_64_top.sv =====
// miller_rabin_prime_test_64_top: 64-bit primality tester, one number at a time
// below-two candidates go straight to the result; trial division folds the candidate
// in eight-bit chunks for each of up to 168 small primes; then montgomery setup and
// montgomery multiplies on the shared 32x32 multiplier, up to 126 multiplies per base, six bases
// throughput: one beat in flight; a new beat is taken while the last result waits
// reset: rst_n synchronous active low, clears the sequencer and the output valid
module miller_rabin_prime_test_64_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_candidate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_prime,
  output logic [2:0]  out_outcome
);
  import mrpt_pkg::*;

  // command and status between sequencer and datapath
  mrpt_cmd_t cmd;
  mrpt_sts_t sts;

  // sequencer: trial division walk, setup count, base loop, squaring loop
  mrpt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_is_prime (out_is_prime),
    .out_outcome  (out_outcome),
    .sts          (sts),
    .cmd          (cmd)
  );

  // datapath: holds the candidate, montgomery constants and the modular power
  mrpt_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_candidate (in_candidate),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
